// ===== rtl/bsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared constants for the pipelined radix-2 Booth multiplier.
// ----------------------------------------------------------------------------
package bsm_pkg;

	// default operand width
	localparam int OPERAND_BITS_DEF = 16;

endpackage

// ===== rtl/booth_signed_multiplier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// booth_signed_multiplier_unit
// Signed radix-2 Booth multiplier, one Booth step per pipeline stage.
// ----------------------------------------------------------------------------
// A request is taken on every cycle with start high; busy is always low. The
// product of a request shows on product with done high for one cycle, after
// passing one register stage per Booth step plus an
// output register. The receiver cannot stall, so results leave in request
// order with no gaps between back-to-back requests. Products are exact, the
// most negative operands included.
// ----------------------------------------------------------------------------
module booth_signed_multiplier_unit
	import bsm_pkg::*;
#(
	parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [OPERAND_BITS-1:0]   multiplicand,
	input  logic signed [OPERAND_BITS-1:0]   multiplier,
	output logic                             done,
	output logic signed [2*OPERAND_BITS-1:0] product
);

	localparam int LATENCY = OPERAND_BITS + 1;

	logic                           valid_w [0:OPERAND_BITS];
	logic signed [OPERAND_BITS-1:0] mcand_w [0:OPERAND_BITS];
	logic signed [OPERAND_BITS:0]   acc_w   [0:OPERAND_BITS];
	logic        [OPERAND_BITS-1:0] q_w     [0:OPERAND_BITS];
	logic                           qprev_w [0:OPERAND_BITS];

	logic                             done_q;
	logic signed [2*OPERAND_BITS-1:0] product_q;

	assign busy = 1'b0;

	assign valid_w[0] = start & ~busy;
	assign mcand_w[0] = multiplicand;
	assign acc_w[0]   = '0;
	assign q_w[0]     = multiplier;
	assign qprev_w[0] = 1'b0;

	for (genvar i = 0; i < OPERAND_BITS; i++) begin : g_step
		bsm_step #(
			.OPERAND_BITS(OPERAND_BITS)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (valid_w[i]),
			.mcand_in (mcand_w[i]),
			.acc_in   (acc_w[i]),
			.q_in     (q_w[i]),
			.qprev_in (qprev_w[i]),
			.valid_s1 (valid_w[i+1]),
			.mcand_s1 (mcand_w[i+1]),
			.acc_s1   (acc_w[i+1]),
			.q_s1     (q_w[i+1]),
			.qprev_s1 (qprev_w[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_w[OPERAND_BITS];
		end
	end

	always_ff @(posedge clk) begin
		product_q <= {acc_w[OPERAND_BITS][OPERAND_BITS-1:0], q_w[OPERAND_BITS]};
	end

	assign done    = done_q;
	assign product = product_q;

	// a result only for a request taken earlier at the pipeline input
	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("done without matching request");

	// zero multiplier gives zero product
	a_zero_multiplier: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(multiplier == '0, LATENCY) |-> product == '0)
		else $error("nonzero product for zero multiplier");

	// unit multiplicand passes the multiplier through, sign extended
	a_unit_multiplicand: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(multiplicand == OPERAND_BITS'(1), LATENCY)
		|-> product == (2*OPERAND_BITS)'($past(multiplier, LATENCY)))
		else $error("wrong product for unit multiplicand");

endmodule

// ===== rtl/bsm_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_step
// One radix-2 Booth step: add, subtract or keep the multiplicand on the
// accumulator, then an arithmetic right shift of {acc, q, qprev}, registered.
// ----------------------------------------------------------------------------
module bsm_step
	import bsm_pkg::*;
#(
	parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           valid_in,
	input  logic signed [OPERAND_BITS-1:0] mcand_in,
	input  logic signed [OPERAND_BITS:0]   acc_in,
	input  logic        [OPERAND_BITS-1:0] q_in,
	input  logic                           qprev_in,
	output logic                           valid_s1,
	output logic signed [OPERAND_BITS-1:0] mcand_s1,
	output logic signed [OPERAND_BITS:0]   acc_s1,
	output logic        [OPERAND_BITS-1:0] q_s1,
	output logic                           qprev_s1
);

	typedef enum logic [1:0] {
		OP_NONE,
		OP_ADD,
		OP_SUB
	} booth_op_t;

	booth_op_t                    op;
	logic signed [OPERAND_BITS:0] mcand_ext;
	logic signed [OPERAND_BITS:0] acc_sum;

	assign mcand_ext = {mcand_in[OPERAND_BITS-1], mcand_in};

	always_comb begin
		unique case ({q_in[0], qprev_in})
			2'b10:   op = OP_SUB;
			2'b01:   op = OP_ADD;
			default: op = OP_NONE;
		endcase
	end

	always_comb begin
		case (op)
			OP_SUB:  acc_sum = acc_in - mcand_ext;
			OP_ADD:  acc_sum = acc_in + mcand_ext;
			default: acc_sum = acc_in;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		mcand_s1 <= mcand_in;
		acc_s1   <= acc_sum >>> 1;
		q_s1     <= {acc_sum[0], q_in[OPERAND_BITS-1:1]};
		qprev_s1 <= q_in[0];
	end

endmodule

// ===== tb/booth_product_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// booth_product_checker
// Watches the request and result sides of the Booth multiplier. It computes
// the expected product of each accepted request with its own radix-2 Booth
// steps, then checks every product strobe against the oldest open request.
// ----------------------------------------------------------------------------
module booth_product_checker #(
	parameter int OPERAND_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic signed [OPERAND_BITS-1:0]   multiplicand,
	input  logic signed [OPERAND_BITS-1:0]   multiplier,
	input  logic                             done,
	input  logic signed [2*OPERAND_BITS-1:0] product,
	output int                               errors,
	output int                               open_requests
);

	localparam int N = OPERAND_BITS;

	logic signed [2*N-1:0] expected_products[$];

	// accumulator has one guard bit above the operand width
	function automatic logic signed [2*N-1:0] booth_product(
		input logic signed [N-1:0] mcand,
		input logic [N-1:0]        mplier
	);
		logic signed [N:0] acc;
		logic [N-1:0]      q;
		logic              q_prev;
		acc    = '0;
		q      = mplier;
		q_prev = 1'b0;
		for (int step = 0; step < N; step++) begin
			case ({q[0], q_prev})
				2'b10: begin
					acc = acc - {mcand[N-1], mcand};
				end
				2'b01: begin
					acc = acc + {mcand[N-1], mcand};
				end
				default: begin
				end
			endcase
			q_prev = q[0];
			q      = {acc[0], q[N-1:1]};
			acc    = acc >>> 1;
		end
		return {acc[N-1:0], q};
	endfunction

	initial begin
		errors        = 0;
		open_requests = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		logic signed [2*N-1:0] want;
		if (!arst_n) begin
			expected_products.delete();
			open_requests = 0;
		end else begin
			if (done) begin
				if (expected_products.size() == 0) begin
					$error("product with no request open: actual %0d", product);
					errors++;
				end else begin
					want = expected_products.pop_front();
					if (product !== want) begin
						$error("product mismatch: expected %0d, actual %0d", want, product);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				expected_products.push_back(booth_product(multiplicand, multiplier));
			end
			open_requests = expected_products.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives signed operand pairs into the Booth multiplier: a directed set of
// extreme operands, then random pairs weighted toward corner values, with
// random idle gaps between requests. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	import bsm_pkg::*;

	localparam int N           = OPERAND_BITS_DEF;
	localparam int RANDOM_REQS = 1900;

	localparam logic signed [N-1:0] OP_MIN = {1'b1, {(N-1){1'b0}}};
	localparam logic signed [N-1:0] OP_MAX = {1'b0, {(N-1){1'b1}}};
	localparam logic signed [N-1:0] OP_ONE = {{(N-1){1'b0}}, 1'b1};
	localparam logic signed [N-1:0] OP_NEG = {N{1'b1}};
	localparam logic signed [N-1:0] OP_ZERO = '0;
	localparam logic signed [N-1:0] OP_ALT_A = {(N/2){2'b01}};
	localparam logic signed [N-1:0] OP_ALT_B = {(N/2){2'b10}};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic signed [N-1:0]     multiplicand = '0;
	logic signed [N-1:0]     multiplier = '0;
	logic                    busy;
	logic                    done;
	logic signed [2*N-1:0]   product;
	int                      errors;
	int                      open_requests;

	booth_signed_multiplier_unit #(
		.OPERAND_BITS(N)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.multiplicand (multiplicand),
		.multiplier   (multiplier),
		.done         (done),
		.product      (product)
	);

	booth_product_checker #(
		.OPERAND_BITS(N)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.multiplicand  (multiplicand),
		.multiplier    (multiplier),
		.done          (done),
		.product       (product),
		.errors        (errors),
		.open_requests (open_requests)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic signed [N-1:0] pick_operand();
		logic signed [N-1:0] one_hot;
		one_hot = OP_ONE << $urandom_range(0, N - 1);
		case ($urandom_range(0, 13))
			0:       return OP_MIN;
			1:       return OP_MAX;
			2:       return OP_ZERO;
			3:       return OP_NEG;
			4:       return OP_ONE;
			5:       return one_hot;
			6:       return ~one_hot;
			default: return N'($urandom);
		endcase
	endfunction

	function automatic int pick_gap(input bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 45)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(5, 30);
	endfunction

	// holds start high until the request is taken, then, for a positive gap, drops start and idles
	task automatic send_request(
		input logic signed [N-1:0] a,
		input logic signed [N-1:0] b,
		input int                  gap
	);
		start        <= 1'b1;
		multiplicand <= a;
		multiplier   <= b;
		do
			@(posedge clk);
		while (busy);
		if (gap > 0) begin
			start        <= 1'b0;
			multiplicand <= N'($urandom);
			multiplier   <= N'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		logic signed [N-1:0] directed_a[$];
		logic signed [N-1:0] directed_b[$];
		bit                  burst;
		int                  waited;
		directed_a = '{OP_ZERO, OP_MAX, OP_MIN, OP_MIN, OP_MAX, OP_NEG, OP_ONE, OP_MIN,
			OP_NEG, OP_MIN, OP_ZERO, OP_ALT_A, OP_ALT_B, OP_ALT_A, OP_ONE, OP_NEG,
			OP_MAX, OP_ZERO, OP_ALT_B, OP_MIN};
		directed_b = '{OP_ZERO, OP_MAX, OP_MIN, OP_MAX, OP_MIN, OP_NEG, OP_NEG, OP_NEG,
			OP_MIN, OP_ONE, OP_MIN, OP_ALT_B, OP_ALT_A, OP_ALT_A, OP_ONE, OP_ONE,
			OP_ZERO, OP_MAX, OP_ALT_B, OP_ZERO};
		burst = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_a[i])
			send_request(directed_a[i], directed_b[i], pick_gap(i < 8));

		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i % 50 == 0)
				burst = ($urandom_range(0, 3) == 0);
			send_request(pick_operand(), pick_operand(), pick_gap(burst));
		end
		start <= 1'b0;

		waited = 0;
		while (open_requests != 0 && waited < 4 * N + 100) begin
			@(posedge clk);
			waited++;
		end
		repeat (N + 5) @(posedge clk);

		if (open_requests != 0)
			$error("%0d requests never produced a product", open_requests);
		if (errors == 0 && open_requests == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
